/* hw/rtl/socd_cleaner_with_auto_game_mode_top_assert.svh */
// Assertion macros for the direction-key cleaner checker.
// Used by socd_cleaner_with_auto_game_mode_top_chk; no other dependencies.
`ifndef SOCD_CLEANER_WITH_AUTO_GAME_MODE_TOP_ASSERT_SVH
`define SOCD_CLEANER_WITH_AUTO_GAME_MODE_TOP_ASSERT_SVH

// same-cycle implication
`define SOCD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("socd assertion failed");

// next-cycle implication
`define SOCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("socd assertion failed");

`endif

/* hw/rtl/socd_pkg.sv */
// Shared types, codes and helper functions for the direction-key cleaner.
// No dependencies.
package socd_pkg;

   localparam int ROW_COUNT = 8;
   localparam int COL_COUNT = 32;

   localparam logic [2:0] W_ROW      = 3'd2;
   localparam logic [2:0] ASD_ROW    = 3'd3;
   localparam logic [4:0] W_COL      = 5'd2;
   localparam logic [4:0] A_COL      = 5'd1;
   localparam logic [4:0] S_COL      = 5'd2;
   localparam logic [4:0] D_COL      = 5'd3;
   localparam logic [2:0] HOME_ROW   = 3'd3;
   localparam logic [4:0] HOME_COL_LO = 5'd7;
   localparam logic [4:0] HOME_COL_HI = 5'd10;

   localparam logic [3:0] SEEN_ALL      = 4'hF;
   localparam logic [3:0] COUNT_MAX     = 4'd15;
   localparam logic [3:0] THRESH_RESET  = 4'd5;

   typedef enum logic [2:0] {
      DIR_NONE = 3'd0,
      DIR_W    = 3'd1,
      DIR_A    = 3'd2,
      DIR_S    = 3'd3,
      DIR_D    = 3'd4
   } dir_type;

   typedef enum logic [1:0] {
      VERT_NONE = 2'd0,
      VERT_W    = 2'd1,
      VERT_S    = 2'd2
   } vert_type;

   typedef enum logic [1:0] {
      HORIZ_NONE = 2'd0,
      HORIZ_A    = 2'd1,
      HORIZ_D    = 2'd2
   } horiz_type;

   typedef struct packed {
      logic [2:0] key_row;
      logic [4:0] key_col;
      logic       pressed;
      logic       key_is_gui;
   } req_type;

   typedef struct packed {
      logic game_active;
      logic drive_valid;
      logic drive_up;
      logic drive_left;
      logic drive_down;
      logic drive_right;
      logic entered_pulse;
      logic exited_pulse;
   } rsp_type;

   typedef struct packed {
      dir_type dir;
      logic    home_exit;
   } key_info_type;

   // bit order: 0 W, 1 A, 2 S, 3 D
   function automatic logic [3:0] dir_bit(dir_type d);
      logic [3:0] b;
      unique case (d)
         DIR_W:   b = 4'b0001;
         DIR_A:   b = 4'b0010;
         DIR_S:   b = 4'b0100;
         DIR_D:   b = 4'b1000;
         default: b = 4'b0000;
      endcase
      return b;
   endfunction

   // last-input priority per opposing pair
   function automatic logic [3:0] resolve(logic [3:0] held, vert_type lv, horiz_type lh);
      logic [3:0] r;
      r = 4'b0000;
      if (held[0] && held[2]) begin
         r = r | ((lv == VERT_W) ? 4'b0001 : 4'b0100);
      end else begin
         r = r | {1'b0, held[2], 1'b0, held[0]};
      end
      if (held[1] && held[3]) begin
         r = r | ((lh == HORIZ_A) ? 4'b0010 : 4'b1000);
      end else begin
         r = r | {held[3], 1'b0, held[1], 1'b0};
      end
      return r;
   endfunction

endpackage

/* hw/rtl/socd_decode.sv */
// Matrix position decoder: direction key and right home-row detection.
// Depends on socd_pkg.
module socd_decode (
   input  logic [2:0]            key_row,
   input  logic [4:0]            key_col,
   output socd_pkg::key_info_type info
);
   import socd_pkg::*;

   logic in_matrix;

   assign in_matrix = (32'(key_row) < ROW_COUNT) && (32'(key_col) < COL_COUNT);

   always_comb begin
      info.dir = DIR_NONE;
      if (in_matrix) begin
         if (key_row == W_ROW && key_col == W_COL) begin
            info.dir = DIR_W;
         end else if (key_row == ASD_ROW && key_col == A_COL) begin
            info.dir = DIR_A;
         end else if (key_row == ASD_ROW && key_col == S_COL) begin
            info.dir = DIR_S;
         end else if (key_row == ASD_ROW && key_col == D_COL) begin
            info.dir = DIR_D;
         end
      end
      info.home_exit = in_matrix && key_row == HOME_ROW &&
                       key_col >= HOME_COL_LO && key_col <= HOME_COL_HI;
   end

endmodule

/* hw/rtl/socd_core.sv */
// Cleaner state and single-pass event logic: held/resolved keys, game mode,
// entry tracking. Depends on socd_pkg and socd_decode.
module socd_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  socd_pkg::req_type item,
   input  logic [3:0]        threshold,
   output socd_pkg::rsp_type result
);
   import socd_pkg::*;

   key_info_type info;

   logic [3:0] held_ff, held_in;
   logic [3:0] resolved_ff, resolved_in;
   vert_type   last_vert_ff, last_vert_in;
   horiz_type  last_horiz_ff, last_horiz_in;
   logic       game_ff, game_in;
   logic [3:0] seen_ff, seen_in;
   logic [3:0] count_ff, count_in;
   dir_type    prev_dir_ff, prev_dir_in;

   socd_decode u_decode (
      .key_row (item.key_row),
      .key_col (item.key_col),
      .info    (info)
   );

   always_comb begin
      logic [3:0] bit_sel;
      logic [3:0] drive_bits;
      logic       drive;
      logic       entered;
      logic       exited;

      bit_sel       = dir_bit(info.dir);
      held_in       = held_ff;
      resolved_in   = resolved_ff;
      last_vert_in  = last_vert_ff;
      last_horiz_in = last_horiz_ff;
      game_in       = game_ff;
      seen_in       = seen_ff;
      count_in      = count_ff;
      prev_dir_in   = prev_dir_ff;
      drive         = 1'b0;
      drive_bits    = 4'b0000;
      entered       = 1'b0;
      exited        = 1'b0;

      if (info.dir != DIR_NONE) begin
         if (item.pressed) begin
            held_in = held_ff | bit_sel;
            if (info.dir == DIR_W) begin
               last_vert_in = VERT_W;
            end else if (info.dir == DIR_S) begin
               last_vert_in = VERT_S;
            end else if (info.dir == DIR_A) begin
               last_horiz_in = HORIZ_A;
            end else begin
               last_horiz_in = HORIZ_D;
            end
         end else begin
            held_in = held_ff & ~bit_sel;
         end
         resolved_in = resolve(held_in, last_vert_in, last_horiz_in);
      end

      if (game_ff) begin
         drive      = 1'b1;
         drive_bits = resolved_in;
         if (item.pressed && (item.key_is_gui || info.home_exit)) begin
            resolved_in = 4'b0000;
            game_in     = 1'b0;
            exited      = 1'b1;
         end
      end else if (item.pressed) begin
         if (info.dir != DIR_NONE) begin
            seen_in = seen_ff | bit_sel;
            if (info.dir != prev_dir_ff) begin
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 4'd1;
               end
               prev_dir_in = info.dir;
            end
            if (seen_in == SEEN_ALL || count_in >= threshold) begin
               seen_in     = 4'b0000;
               count_in    = 4'd0;
               prev_dir_in = DIR_NONE;
               game_in     = 1'b1;
               entered     = 1'b1;
               drive       = 1'b1;
               drive_bits  = resolved_in;
            end
         end else begin
            seen_in     = 4'b0000;
            count_in    = 4'd0;
            prev_dir_in = DIR_NONE;
         end
      end

      result.game_active   = game_in;
      result.drive_valid   = drive;
      result.drive_up      = drive_bits[0];
      result.drive_left    = drive_bits[1];
      result.drive_down    = drive_bits[2];
      result.drive_right   = drive_bits[3];
      result.entered_pulse = entered;
      result.exited_pulse  = exited;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= 4'b0000;
         resolved_ff   <= 4'b0000;
         last_vert_ff  <= VERT_NONE;
         last_horiz_ff <= HORIZ_NONE;
         game_ff       <= 1'b0;
         seen_ff       <= 4'b0000;
         count_ff      <= 4'd0;
         prev_dir_ff   <= DIR_NONE;
      end else if (advance) begin
         held_ff       <= held_in;
         resolved_ff   <= resolved_in;
         last_vert_ff  <= last_vert_in;
         last_horiz_ff <= last_horiz_in;
         game_ff       <= game_in;
         seen_ff       <= seen_in;
         count_ff      <= count_in;
         prev_dir_ff   <= prev_dir_in;
      end
   end

endmodule

/* hw/rtl/socd_cleaner_with_auto_game_mode_top.sv */
// Top level of the direction-key cleaner with automatic game mode.
// Depends on socd_pkg and socd_core.
//
// Takes one key event per cycle while req_stall is low and returns exactly one
// result item per event: each event first sits in the input register, then
// the event logic runs in a single pass into the result register. Sustained
// rate is one item per clock; req_stall rises only while a result is held by
// rsp_stall and the input register is occupied. csr_ready is always high;
// write alternation_threshold only while no items are in flight.
module socd_cleaner_with_auto_game_mode_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  socd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output socd_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_data
);
   import socd_pkg::*;

   logic       in_valid_ff;
   req_type    in_data_ff;
   logic       out_valid_ff;
   rsp_type    out_data_ff;
   logic [3:0] threshold_ff;
   logic       out_blocked;
   logic       advance;
   rsp_type    result;

   assign out_blocked = out_valid_ff && rsp_stall;
   assign advance     = in_valid_ff && !out_blocked;
   assign req_stall   = in_valid_ff && out_blocked;
   assign rsp_valid   = out_valid_ff;
   assign rsp_data    = out_data_ff;
   assign csr_ready   = 1'b1;

   socd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (in_data_ff),
      .threshold (threshold_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         threshold_ff <= THRESH_RESET;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

endmodule

/* hw/rtl/socd_cleaner_with_auto_game_mode_top_chk.sv */
// Port-level checker for the direction-key cleaner, bound to the top level.
// Depends on socd_pkg and socd_cleaner_with_auto_game_mode_top_assert.svh.
`include "socd_cleaner_with_auto_game_mode_top_assert.svh"

module socd_cleaner_with_auto_game_mode_top_chk (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input socd_pkg::rsp_type rsp_data
);
   import socd_pkg::*;

   logic enter_ok;
   logic exit_ok;
   logic any_drive;
   logic pair_ok;

   assign enter_ok  = rsp_data.game_active && rsp_data.drive_valid && !rsp_data.exited_pulse;
   assign exit_ok   = !rsp_data.game_active && rsp_data.drive_valid;
   assign any_drive = rsp_data.drive_up || rsp_data.drive_left || rsp_data.drive_down ||
                      rsp_data.drive_right;
   assign pair_ok   = !(rsp_data.drive_up && rsp_data.drive_down) &&
                      !(rsp_data.drive_left && rsp_data.drive_right);

   `SOCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `SOCD_ASSERT_IMPLY(a_enter, clock, reset, rsp_valid && rsp_data.entered_pulse, enter_ok)
   `SOCD_ASSERT_IMPLY(a_exit, clock, reset, rsp_valid && rsp_data.exited_pulse, exit_ok)
   `SOCD_ASSERT_IMPLY(a_no_drive, clock, reset, rsp_valid && !rsp_data.drive_valid, !any_drive)
   `SOCD_ASSERT_IMPLY(a_pairs, clock, reset, rsp_valid, pair_ok)

endmodule

bind socd_cleaner_with_auto_game_mode_top socd_cleaner_with_auto_game_mode_top_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
